/* design/rob_pkg.sv */
// shared types and codes for the reorder buffer
`timescale 1ns / 1ps
`default_nettype none

package rob_pkg;

	localparam int TAG_W   = 5;
	localparam int DEST_W  = 6;
	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		KIND_ALLOC       = 2'd0,
		KIND_READY_INT   = 2'd1,
		KIND_READY_FLOAT = 2'd2,
		KIND_COMMIT      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_EMPTY     = 2'd2,
		STATUS_NOT_READY = 2'd3
	} status_t;

	// which form the result register takes
	typedef enum logic [1:0] {
		SEL_STATUS = 2'd0,
		SEL_ALLOC  = 2'd1,
		SEL_RETIRE = 2'd2
	} res_sel_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_RETIRE = 1'b1
	} state_t;

	typedef struct packed {
		logic     alloc;
		logic     mark_int;
		logic     mark_float;
		logic     retire;
		logic     load_out;
		res_sel_t sel;
		status_t  status;
	} rob_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic head_ready;
	} rob_stat_t;

endpackage

`default_nettype wire

/* design/rob_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rob_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* design/rob_ctrl.sv */
// request sequencer and result register control
`timescale 1ns / 1ps
`default_nettype none

module rob_ctrl
	import rob_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire kind_t     kind,
	output logic           res_valid,
	input  wire logic      res_stall,
	input  wire rob_stat_t stat,
	output rob_cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	logic   out_free;
	logic   accept;

	// result register can take a new result this cycle
	assign out_free  = !res_valid_q || !res_stall;
	assign req_stall = (state_q != S_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && kind == KIND_COMMIT && !stat.empty && stat.head_ready) begin
					state_d = S_RETIRE;
				end
			end
			S_RETIRE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (kind) inside
						KIND_ALLOC: begin
							cmd.load_out = 1'b1;
							if (stat.full) begin
								cmd.sel    = SEL_STATUS;
								cmd.status = STATUS_FULL;
							end else begin
								cmd.alloc  = 1'b1;
								cmd.sel    = SEL_ALLOC;
								cmd.status = STATUS_OK;
							end
						end
						KIND_READY_INT, KIND_READY_FLOAT: begin
							cmd.mark_int   = (kind == KIND_READY_INT);
							cmd.mark_float = (kind == KIND_READY_FLOAT);
							cmd.load_out   = 1'b1;
							cmd.sel        = SEL_STATUS;
							cmd.status     = STATUS_OK;
						end
						KIND_COMMIT: begin
							// a good commit goes to S_RETIRE and waits there for the registered entry read
							if (stat.empty) begin
								cmd.load_out = 1'b1;
								cmd.sel      = SEL_STATUS;
								cmd.status   = STATUS_EMPTY;
							end else if (!stat.head_ready) begin
								cmd.load_out = 1'b1;
								cmd.sel      = SEL_STATUS;
								cmd.status   = STATUS_NOT_READY;
							end
						end
					endcase
				end
			end
			S_RETIRE: begin
				if (out_free) begin
					cmd.retire   = 1'b1;
					cmd.load_out = 1'b1;
					cmd.sel      = SEL_RETIRE;
					cmd.status   = STATUS_OK;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/rob_datapath.sv */
// pointers, ready bits, entry rams and result register
`timescale 1ns / 1ps
`default_nettype none

module rob_datapath
	import rob_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rob_cmd_t                  cmd,
	output rob_stat_t                      stat,
	input  wire logic signed [DEST_W-1:0]  dest_reg,
	input  wire logic                      is_float,
	input  wire logic [TAG_W-1:0]          entry_index,
	input  wire logic [VALUE_W-1:0]        result_value,
	output logic [1:0]                     status,
	output logic [TAG_W-1:0]               alloc_tag,
	output logic                           retired,
	output logic                           write_enable,
	output logic signed [DEST_W-1:0]       retire_dest,
	output logic                           retire_float,
	output logic [VALUE_W-1:0]             retire_value,
	output logic [TAG_W-1:0]               retire_tag
);

	localparam int PW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);

	logic [PW-1:0]      head_q;
	logic [PW-1:0]      tail_q;
	logic [OW-1:0]      occ_q;
	logic [DEPTH-1:0]   ready_q;
	logic [PW-1:0]      idx;
	logic               idx_ok;
	logic               mark;

	logic               dest_we;
	logic               flag_we;
	logic [PW-1:0]      flag_waddr;
	logic               flag_wdata;
	logic               int_we;
	logic [PW-1:0]      int_waddr;
	logic [VALUE_W-1:0] int_wdata;
	logic               fval_we;

	logic [DEST_W-1:0]  dest_rd;
	logic               flag_rd;
	logic [VALUE_W-1:0] int_rd;
	logic [VALUE_W-1:0] fval_rd;

	status_t            status_q;
	logic [TAG_W-1:0]   alloc_tag_q;
	logic               retired_q;
	logic               write_enable_q;
	logic [DEST_W-1:0]  retire_dest_q;
	logic               retire_float_q;
	logic [VALUE_W-1:0] retire_value_q;
	logic [TAG_W-1:0]   retire_tag_q;

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign idx    = PW'(entry_index);
	assign idx_ok = (32'(entry_index) < 32'(DEPTH));
	assign mark   = (cmd.mark_int || cmd.mark_float) && idx_ok;

	assign stat.full       = (occ_q == OW'(DEPTH));
	assign stat.empty      = (occ_q == '0);
	assign stat.head_ready = ready_q[head_q];

	// write port steering: allocate uses the tail, mark uses the given index
	assign dest_we    = cmd.alloc;
	assign flag_we    = cmd.alloc || (cmd.mark_float && idx_ok);
	assign flag_waddr = cmd.alloc ? tail_q : idx;
	assign flag_wdata = cmd.alloc ? is_float : 1'b1;
	assign int_we     = cmd.alloc || (cmd.mark_int && idx_ok);
	assign int_waddr  = cmd.alloc ? tail_q : idx;
	assign int_wdata  = cmd.alloc ? '0 : result_value;
	assign fval_we    = cmd.mark_float && idx_ok;

	rob_ram #(.WIDTH(DEST_W), .DEPTH(DEPTH)) u_dest_ram (
		.clk   (clk),
		.we    (dest_we),
		.waddr (tail_q),
		.wdata (dest_reg),
		.raddr (head_q),
		.rdata (dest_rd)
	);

	rob_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.raddr (head_q),
		.rdata (flag_rd)
	);

	rob_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_int_ram (
		.clk   (clk),
		.we    (int_we),
		.waddr (int_waddr),
		.wdata (int_wdata),
		.raddr (head_q),
		.rdata (int_rd)
	);

	rob_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_fval_ram (
		.clk   (clk),
		.we    (fval_we),
		.waddr (idx),
		.wdata (result_value),
		.raddr (head_q),
		.rdata (fval_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			ready_q <= '0;
		end else begin
			if (cmd.alloc) begin
				tail_q          <= advance(tail_q);
				occ_q           <= occ_q + 1'b1;
				ready_q[tail_q] <= 1'b0;
			end else if (mark) begin
				ready_q[idx] <= 1'b1;
			end else if (cmd.retire) begin
				head_q          <= advance(head_q);
				occ_q           <= occ_q - 1'b1;
				ready_q[head_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q       <= cmd.status;
			alloc_tag_q    <= '0;
			retired_q      <= 1'b0;
			write_enable_q <= 1'b0;
			retire_dest_q  <= '0;
			retire_float_q <= 1'b0;
			retire_value_q <= '0;
			retire_tag_q   <= '0;
			case (cmd.sel)
				SEL_ALLOC: begin
					alloc_tag_q <= TAG_W'(tail_q);
				end
				SEL_RETIRE: begin
					retired_q      <= 1'b1;
					write_enable_q <= !dest_rd[DEST_W-1];
					retire_dest_q  <= dest_rd;
					retire_float_q <= flag_rd;
					retire_value_q <= flag_rd ? fval_rd : int_rd;
					retire_tag_q   <= TAG_W'(head_q);
				end
				default: begin
				end
			endcase
		end
	end

	assign status       = status_q;
	assign alloc_tag    = alloc_tag_q;
	assign retired      = retired_q;
	assign write_enable = write_enable_q;
	assign retire_dest  = retire_dest_q;
	assign retire_float = retire_float_q;
	assign retire_value = retire_value_q;
	assign retire_tag   = retire_tag_q;

endmodule

`default_nettype wire

/* design/reorder_buffer_core.sv */
// top level of the circular reorder buffer
// each request is one operation: allocate an entry at the tail, mark an
// entry ready with an integer or float result, or commit the head entry.
// every request gives exactly one result on the result channel.
// request channel: req_valid / req_stall, accepted when valid and not stalled
// result channel: res_valid / res_stall, taken when valid and not stalled
// results: allocate, mark ready and a refused commit show their result
// in the cycle after acceptance; a commit that retires goes to the retire
// state, reads the entry rams at head and then loads the result register
// throughput: allocate and mark ready one per cycle unless stalled;
// a retiring commit holds off requests for the registered read at head
// reset clears pointers, occupancy and all ready bits at once; no clearing
// pass, requests are taken in the first cycle after reset
// when the receiver stalls, the result register holds and req_stall rises
// as soon as a second result would have nowhere to go
// a retired entry gives its tag so outside logic can clear alias table
// entries and rebroadcast the value
`timescale 1ns / 1ps
`default_nettype none

module reorder_buffer_core
	import rob_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// request channel
	input  wire logic                     req_valid,
	output logic                          req_stall,
	input  wire logic [1:0]               kind,
	input  wire logic signed [DEST_W-1:0] dest_reg,
	input  wire logic                     is_float,
	input  wire logic [TAG_W-1:0]         entry_index,
	input  wire logic [VALUE_W-1:0]       result_value,
	// result channel
	output logic                          res_valid,
	input  wire logic                     res_stall,
	output logic [1:0]                    status,
	output logic [TAG_W-1:0]              alloc_tag,
	output logic                          retired,
	output logic                          write_enable,
	output logic signed [DEST_W-1:0]      retire_dest,
	output logic                          retire_float,
	output logic [VALUE_W-1:0]            retire_value,
	output logic [TAG_W-1:0]              retire_tag
);

	rob_cmd_t  cmd;
	rob_stat_t stat;

	// sequencer: decodes the request, checks full / empty / head ready
	rob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind_t'(kind)),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// entry storage, pointers and the result register
	rob_datapath #(.DEPTH(DEPTH)) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.dest_reg     (dest_reg),
		.is_float     (is_float),
		.entry_index  (entry_index),
		.result_value (result_value),
		.status       (status),
		.alloc_tag    (alloc_tag),
		.retired      (retired),
		.write_enable (write_enable),
		.retire_dest  (retire_dest),
		.retire_float (retire_float),
		.retire_value (retire_value),
		.retire_tag   (retire_tag)
	);

endmodule

`default_nettype wire

/* design/rob_checker.sv */
// port level checks for the reorder buffer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module rob_checker
	import rob_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     req_valid,
	input wire logic                     req_stall,
	input wire logic [1:0]               kind,
	input wire logic                     res_valid,
	input wire logic                     res_stall,
	input wire logic [1:0]               status,
	input wire logic [TAG_W-1:0]         alloc_tag,
	input wire logic                     retired,
	input wire logic                     write_enable,
	input wire logic signed [DEST_W-1:0] retire_dest,
	input wire logic                     retire_float,
	input wire logic [VALUE_W-1:0]       retire_value,
	input wire logic [TAG_W-1:0]         retire_tag
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(status) && $stable(retired)
			&& $stable(retire_value) && $stable(retire_tag) && $stable(alloc_tag))
		else $error("stalled result changed");

	// allocate and mark ready answer in the next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && kind != KIND_COMMIT |=> res_valid)
		else $error("allocate or mark ready result missing");

	// a retirement always reports ok
	a_retire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && retired |-> status == STATUS_OK && alloc_tag == '0)
		else $error("retired entry with bad status");

	// nothing retired means no register write fields
	a_no_retire_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !retired |-> !write_enable && !retire_float
			&& retire_value == '0 && retire_tag == '0 && retire_dest == '0)
		else $error("retire fields set without retirement");

	// refused requests carry no tag
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != STATUS_OK |-> alloc_tag == '0 && !retired)
		else $error("refused request carries a tag");

endmodule

bind reorder_buffer_core rob_checker u_rob_checker (.*);

`default_nettype wire
